// ----- hdl/sha256_pkg.sv -----
// sha256_pkg: shared types, constants and round functions for the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps

package sha256_pkg;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        BLK_NONE = 2'd0,
        BLK_PAD  = 2'd1,
        BLK_ZERO = 2'd2
    } fill_op_t;

    // controller to datapath
    typedef struct packed {
        logic     put_byte;    // place input byte at fill position
        logic     put_pad;     // place 0x80, zero the rest of the block
        logic     zero_head;   // clear words 0..13
        logic     put_len;     // write length into words 14 and 15
        logic     round_start; // load working vars from hash words
        logic     round_step;  // one compression round
        logic     round_fold;  // add working vars into hash words
        logic     hash_init;   // restore initial hash, clear counters
        logic     out_shift;   // rotate hash words for output
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       fill_wrap;  // byte placed completed the block
        logic       pad_long;   // fill position at or past 56
        logic       round_last; // round 63 in progress
    } dp_stat_t;

    localparam word_t INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };

    function automatic word_t ror32(input word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t small_s0(input word_t x);
        small_s0 = ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_s1(input word_t x);
        small_s1 = ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_s0(input word_t x);
        big_s0 = ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic word_t big_s1(input word_t x);
        big_s1 = ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

endpackage

// ----- hdl/sha256_if.sv -----
// sha256_in_if / sha256_out_if: valid/ready channels of the hasher
// depends on nothing
`timescale 1ns / 1ps

interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ----- hdl/sha256_ctrl.sv -----
// sha256_ctrl: sequencer for byte loading, padding, rounds and digest output
// depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_has_byte,
    input  logic                 in_end,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_index,
    input  sha256_pkg::dp_stat_t stat,
    output sha256_pkg::dp_cmd_t  cmd
);
    import sha256_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_FOLD,
        S_PAD,
        S_EMIT
    } state_t;

    state_t     state_reg;
    logic       fin_reg;      // end pending after the running block
    logic       lenblk_reg;   // running block is the final length block
    logic       second_reg;   // running block is first of two padding blocks
    logic [2:0] idx_reg;

    logic acc;
    assign acc       = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign out_index = idx_reg;

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.put_byte = acc && in_has_byte;
            end
            S_ROUND: cmd.round_step = 1'b1;
            S_FOLD:  cmd.round_fold = 1'b1;
            S_PAD:
            begin
                if (second_reg)
                begin
                    cmd.zero_head = 1'b1;
                    cmd.put_len   = 1'b1;
                end
                else
                begin
                    cmd.put_pad = 1'b1;
                    cmd.put_len = !stat.pad_long;
                end
            end
            S_EMIT:
            begin
                cmd.out_shift = out_ready;
                cmd.hash_init = out_ready && (idx_reg == 3'd7);
            end
            default: cmd = '0;
        endcase
        if ((state_reg == S_IDLE && acc && in_has_byte && stat.fill_wrap)
            || state_reg == S_PAD)
            cmd.round_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fin_reg    <= 1'b0;
            lenblk_reg <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        fin_reg <= in_end;
                        if (in_has_byte && stat.fill_wrap)
                        begin
                            lenblk_reg <= 1'b0;
                            state_reg  <= S_ROUND;
                        end
                        else if (in_end)
                        begin
                            second_reg <= 1'b0;
                            state_reg  <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // short pad block carries the length; long one needs another
                    lenblk_reg <= second_reg || !stat.pad_long;
                    second_reg <= !second_reg && stat.pad_long;
                    fin_reg    <= 1'b0;
                    state_reg  <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (stat.round_last)
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    if (lenblk_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (fin_reg || second_reg)
                        state_reg <= S_PAD;
                    else
                        state_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            lenblk_reg <= 1'b0;
                            state_reg  <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/sha256_dpath.sv -----
// sha256_dpath: block buffer, message schedule, round unit and hash words
// depends on sha256_pkg
`timescale 1ns / 1ps

module sha256_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output sha256_pkg::dp_stat_t stat,
    output logic [31:0]          digest_word
);
    import sha256_pkg::*;

    word_t       blk_reg [16];   // schedule window during rounds
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;

    word_t w_new, t1, t2;
    logic [3:0] widx;
    logic [4:0] sh;

    assign widx = fill_reg[5:2];
    assign sh   = 5'd24 - {fill_reg[1:0], 3'b000};

    assign stat.fill_wrap  = (fill_reg == 6'd63);
    assign stat.pad_long   = (fill_reg >= LEN_POS);
    assign stat.round_last = (rnd_reg == 6'd63);
    assign digest_word     = h_reg[0];

    assign w_new = blk_reg[0] + small_s0(blk_reg[1]) + blk_reg[9] + small_s1(blk_reg[14]);
    assign t1 = v_reg[7] + big_s1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[rnd_reg] + blk_reg[0];
    assign t2 = big_s0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // block buffer and schedule window, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
        begin
            if (fill_reg[1:0] == 2'd0)
                blk_reg[widx] <= word_t'(data_byte) << sh;
            else
                blk_reg[widx] <= blk_reg[widx] | (word_t'(data_byte) << sh);
        end
        if (cmd.put_pad)
        begin
            for (int i = 0; i < 16; i++)
            begin
                if (4'(i) == widx)
                begin
                    if (fill_reg[1:0] == 2'd0)
                        blk_reg[i] <= word_t'(PAD_BYTE) << sh;
                    else
                        blk_reg[i] <= blk_reg[i] | (word_t'(PAD_BYTE) << sh);
                end
                else if (4'(i) > widx && !(cmd.put_len && i >= 14))
                    blk_reg[i] <= '0;
            end
        end
        if (cmd.zero_head)
            for (int i = 0; i < 14; i++)
                blk_reg[i] <= '0;
        if (cmd.put_len)
        begin
            blk_reg[14] <= len_reg[63:32];
            blk_reg[15] <= len_reg[31:0];
        end
        if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                blk_reg[i] <= blk_reg[i + 1];
            blk_reg[15] <= w_new;
        end
        if (cmd.round_start)
            v_reg <= h_reg;
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg    <= INIT_H;
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
        end
        else
        begin
            if (cmd.put_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 64'd8;
            end
            if (cmd.round_start)
                rnd_reg <= '0;
            else if (cmd.round_step)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.round_fold)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.hash_init)
            begin
                h_reg    <= INIT_H;
                fill_reg <= '0;
                len_reg  <= '0;
            end
            else if (cmd.out_shift)
            begin
                for (int i = 0; i < 7; i++)
                    h_reg[i] <= h_reg[i + 1];
                h_reg[7] <= h_reg[0];
            end
        end
    end

endmodule

// ----- hdl/sha256_message_hasher.sv -----
// Byte-serial SHA-256 hasher. One item is taken per cycle while loading a block; the
// item that fills a 64-byte block starts 64 rounds on one round unit plus a fold
// step, during which no item is accepted. An end item adds a padding step and a
// compression (both twice if the tail holds 56 or more bytes), then eight digest
// words H0..H7 leave one per cycle as the sink takes them. No clearing pass
// follows reset.
// depends on sha256_pkg, sha256_if, sha256_ctrl, sha256_dpath
`timescale 1ns / 1ps

module sha256_message_hasher (
    input logic        clk,
    input logic        rst_n,
    sha256_in_if.sink  in_ch,
    sha256_out_if.source out_ch
);
    import sha256_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign out_ch.last_word = (out_ch.word_index == 3'd7);

    sha256_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_has_byte (in_ch.has_byte),
        .in_end      (in_ch.end_of_message),
        .in_ready    (in_ch.ready),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_index   (out_ch.word_index),
        .stat        (stat),
        .cmd         (cmd)
    );

    sha256_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (in_ch.data_byte),
        .stat        (stat),
        .digest_word (out_ch.digest_word)
    );

`ifndef SYNTHESIS
    a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready)
        else $error("input accepted during digest output");
    a_round_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.round_step |-> !in_ch.ready && !out_ch.valid)
        else $error("round step outside compression");
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && out_ch.last_word |=> in_ch.ready)
        else $error("hasher not idle after last digest word");
`endif

endmodule

// ----- verif/sha256_message_hasher_tb.sv -----
// sha256_message_hasher_tb: byte-stream stimulus, digest prediction and word-by-word checking
// depends on sha256_pkg, sha256_if and the sha256_message_hasher rtl
`timescale 1ns / 1ps

module sha256_message_hasher_tb;
    import sha256_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } byte_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam word_t START_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    localparam word_t RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2
    };
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_message_hasher uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    byte_item_t   pending_bytes [$];
    digest_item_t expected_digest [$];

    // predictor state
    word_t       run_h [8];
    word_t       blk [16];
    logic [5:0]  fill;
    logic [63:0] msg_bits;

    int  cycle_count;
    int  mismatches;
    int  digests_seen;
    int  bytes_sent;
    int  burst_left;
    int  gap_left;
    bit  hold_drain;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic word_t rot(word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        word_t w [64];
        word_t v [8];
        word_t t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = blk[t];
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + (rot(w[t-15], 7) ^ rot(w[t-15], 18) ^ (w[t-15] >> 3))
                 + w[t-7] + (rot(w[t-2], 17) ^ rot(w[t-2], 19) ^ (w[t-2] >> 10));
        for (int i = 0; i < 8; i++)
            v[i] = run_h[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[t] + w[t];
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            run_h[i] += v[i];
    endtask

    task automatic insert_byte(logic [7:0] b);
        int sh;
        sh = 24 - 8 * fill[1:0];
        if (fill[1:0] == 2'd0)
            blk[fill[5:2]] = word_t'(b) << sh;
        else
            blk[fill[5:2]] |= word_t'(b) << sh;
        fill = fill + 6'd1;
    endtask

    task automatic predict_digest(byte_item_t it);
        digest_item_t d;
        logic [5:0] tail;
        if (it.has_byte)
        begin
            insert_byte(it.data_byte);
            msg_bits += 64'd8;
            if (fill == 6'd0)
                compress_blk();
        end
        if (!it.end_of_message)
            return;
        tail = fill;
        insert_byte(PAD_BYTE);
        for (int i = tail[5:2] + 1; i < 16; i++)
            blk[i] = '0;
        if (tail >= LEN_POS)
        begin
            compress_blk();
            for (int i = 0; i < 14; i++)
                blk[i] = '0;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress_blk();
        for (int k = 0; k < 8; k++)
        begin
            d.digest_word = run_h[k];
            d.word_index  = 3'(k);
            d.last_word   = (k == 7);
            expected_digest.push_back(d);
        end
        run_h = START_H;
        fill = '0;
        msg_bits = '0;
    endtask

    function automatic byte_item_t mk(logic [7:0] b, bit has, bit fin);
        byte_item_t it;
        it.data_byte = b;
        it.has_byte = has;
        it.end_of_message = fin;
        return it;
    endfunction

    // a message of n bytes; the last byte may carry the end or a bare end follows
    task automatic queue_message(int n, bit noise);
        bit end_on_byte;
        end_on_byte = (n > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(0, 7) == 0)
                pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b0));
            pending_bytes.push_back(mk(8'($urandom), 1'b1, end_on_byte && i == n - 1));
        end
        if (!end_on_byte)
            pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b1));
    endtask

    // driver: bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.has_byte <= 1'b0;
            in_ch.end_of_message <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            bytes_sent <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_digest({in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message});
                bytes_sent <= bytes_sent + 1;
            end
            if (in_ch.valid && !in_ch.ready)
                ; // hold the item
            else if (gap_left > 0)
            begin
                in_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_bytes.size() == 0 || hold_drain)
                in_ch.valid <= 1'b0;
            else
            begin
                {in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message} <=
                    pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t got, want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            out_ch.ready <= (cycle_count[9:8] == 2'd0) ? 1'b1
                          : ($urandom_range(0, 3) != 0);
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.digest_word, out_ch.word_index, out_ch.last_word};
                digests_seen++;
                if (expected_digest.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected digest word %h idx %0d", got.digest_word,
                                 got.word_index);
                end
                else
                begin
                    want = expected_digest.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                     want.digest_word, want.word_index, want.last_word,
                                     got.digest_word, got.word_index, got.last_word);
                    end
                end
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** sha256_message_hasher: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        run_h = START_H;
        for (int i = 0; i < 16; i++)
            blk[i] = '0;
        fill = '0;
        msg_bits = '0;
        mismatches = 0;
        digests_seen = 0;
        hold_drain = 1'b0;
        rst_n = 1'b0;

        // directed: empty message, idle item, short extremes
        pending_bytes.push_back(mk(8'hff, 1'b0, 1'b0));
        pending_bytes.push_back(mk(8'h00, 1'b0, 1'b1));
        pending_bytes.push_back(mk(8'h00, 1'b1, 1'b0));
        pending_bytes.push_back(mk(8'hff, 1'b1, 1'b0));
        pending_bytes.push_back(mk(8'haa, 1'b0, 1'b0));
        pending_bytes.push_back(mk(8'h55, 1'b1, 1'b1));
        pending_bytes.push_back(mk(8'h61, 1'b1, 1'b1));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // pause until all digests drain, then long-tail and block-boundary cases
        wait (pending_bytes.size() == 0);
        hold_drain = 1'b1;
        wait (expected_digest.size() == 0 && !in_ch.valid);
        hold_drain = 1'b0;
        queue_message(56, 1'b0);
        queue_message(64, 1'b0);
        queue_message(63, 1'b0);
        queue_message(55, 1'b0);

        // random messages, mostly short with occasional noise items
        for (int n = 0; n < 4; n++)
            queue_message($urandom_range(0, 24), 1'b1);
        for (int n = 0; n < 6; n++)
            pending_bytes.push_back(mk(8'($urandom), 1'b0, 1'b0));

        wait (pending_bytes.size() == 0 && !in_ch.valid);
        wait (expected_digest.size() == 0);
        repeat (200) @(posedge clk);
        $display("sent %0d input items across padding edges and random messages", bytes_sent);
        $display("checked %0d digest words", digests_seen);
        if (mismatches == 0 && expected_digest.size() == 0)
            $display("** sha256_message_hasher: PASSED **");
        else
            $display("** sha256_message_hasher: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sha256_pkg.sv
hdl/sha256_if.sv
hdl/sha256_ctrl.sv
hdl/sha256_dpath.sv
hdl/sha256_message_hasher.sv
verif/sha256_message_hasher_tb.sv
